// File: src/assert_macros.svh
// Assertion macros for the RTL of the descending selection sorter (its top level).
// Every macro samples on the rising edge of aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a plain condition on every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that a trigger on one edge implies a condition on the next edge.
`define ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: src/dss_pkg.sv
// Package for the descending selection sorter: beat types and the control struct.
// Used by dss_cell, dss_ctrl and descending_selection_sorter; depends on nothing.
`timescale 1ns / 1ps

package dss_pkg;

    localparam int VALUE_W = 32;

    // Input beat
    typedef struct packed {
        logic signed [VALUE_W-1:0] sample;
        logic                      final_req;
    } dss_in_t;

    // Result beat
    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      end_of_run;
        logic                      overflow;
    } dss_out_t;

    // Commands from the controller to every cell
    typedef struct packed {
        logic load;   // insert the new value into the chain
        logic shift;  // move every value one cell toward the head
    } dss_ctrl_t;

    // Status of the current result beat
    typedef struct packed {
        logic end_of_run;
        logic overflow;
    } dss_stat_t;

endpackage

// File: src/descending_selection_sorter.sv
// Descending sorter: the top level joining the controller and the chain of cells.
// Depends on dss_pkg, dss_cell, dss_ctrl and assert_macros.svh.
//
// Usage: the s_ channel takes one signed 32-bit sample per beat; final_req marks the
// last beat of a block. Samples are inserted into a chain of DEPTH cells that keeps
// them in descending order, one sample per cycle while s_ready is high. Samples
// beyond DEPTH are dropped and every result of that block carries overflow.
// After the final beat, s_ready falls and the m_ channel presents the sorted values,
// largest first, one beat per cycle, from the head cell of the chain; end_of_run
// marks the last. The first result is valid the cycle after the final beat.
// The single chain either loads or drains, never both at once. When the receiver
// stalls the head value holds until taken. s_ready rises again the cycle after the
// end_of_run beat. Synchronous reset (aresetn low) empties the chain and returns to
// loading.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module descending_selection_sorter #(
    parameter int DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dss_pkg::dss_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dss_pkg::dss_out_t m_data
);
    import dss_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    dss_ctrl_t                 ctl;
    dss_stat_t                 stat;
    logic [CNT_W-1:0]          count;
    logic signed [VALUE_W-1:0] cell_value [DEPTH];
    logic                      cell_disp  [DEPTH];
    logic signed [VALUE_W-1:0] prev_value [DEPTH];
    logic                      prev_disp  [DEPTH];
    logic signed [VALUE_W-1:0] next_value [DEPTH];

    dss_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_final (s_data.final_req),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl),
        .count   (count),
        .stat    (stat)
    );

    // Build the chain; the head has no upper neighbor and the tail no lower one
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign prev_value[i] = cell_value[i];
            assign prev_disp[i]  = 1'b0;
        end else begin : g_body
            assign prev_value[i] = cell_value[i-1];
            assign prev_disp[i]  = cell_disp[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign next_value[i] = cell_value[i];
        end else begin : g_link
            assign next_value[i] = cell_value[i+1];
        end

        dss_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .count      (count),
            .new_value  (s_data.sample),
            .prev_value (prev_value[i]),
            .prev_disp  (prev_disp[i]),
            .next_value (next_value[i]),
            .value      (cell_value[i]),
            .disp       (cell_disp[i])
        );
    end

    // Present the head of the chain
    assign m_data.sorted_value = cell_value[0];
    assign m_data.end_of_run   = stat.end_of_run;
    assign m_data.overflow     = stat.overflow;

    `ASSERT_ALWAYS(a_phase_excl, !(s_ready && m_valid), "load and drain overlap")
    `ASSERT_NEXT(a_final_drains, s_valid && s_ready && s_data.final_req, m_valid,
        "final beat did not start the drain")
    `ASSERT_NEXT(a_descending, m_valid && m_ready && !m_data.end_of_run,
        m_data.sorted_value <= $past(m_data.sorted_value), "results not descending")
    `ASSERT_NEXT(a_end_reloads, m_valid && m_ready && m_data.end_of_run, s_ready,
        "no return to loading after end of run")

endmodule

// File: src/dss_cell.sv
// One cell of the sorting chain: holds one value, kept in descending order along the chain.
// Depends on dss_pkg.
`timescale 1ns / 1ps

module dss_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                                aclk,
    input  dss_pkg::dss_ctrl_t                  ctl,
    input  logic [CNT_W-1:0]                    count,
    input  logic signed [dss_pkg::VALUE_W-1:0]  new_value,
    input  logic signed [dss_pkg::VALUE_W-1:0]  prev_value,
    input  logic                                prev_disp,
    input  logic signed [dss_pkg::VALUE_W-1:0]  next_value,
    output logic signed [dss_pkg::VALUE_W-1:0]  value,
    output logic                                disp
);
    import dss_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      empty;

    // An empty cell ranks below every value
    assign empty = (count <= CNT_W'(INDEX));

    // Displace the held value when the new one beats it strictly
    assign disp = ctl.load && (empty || (new_value > value_reg));

    // Take the upper neighbor's value if it moves down, else the new value; drain upward
    always_comb begin
        if (disp) begin
            value_next = prev_disp ? prev_value : new_value;
        end else if (ctl.shift) begin
            value_next = next_value;
        end else begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: src/dss_ctrl.sv
// Controller of the sorter: load and drain phases, entry count and overflow flag.
// Depends on dss_pkg.
`timescale 1ns / 1ps

module dss_ctrl #(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_final,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output dss_pkg::dss_ctrl_t ctl,
    output logic [CNT_W-1:0]   count,
    output dss_pkg::dss_stat_t stat
);
    import dss_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic             in_fire;
    logic             out_fire;
    logic             room;

    assign s_ready  = (state_reg == ST_LOAD);
    assign m_valid  = (state_reg == ST_DRAIN);
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign room     = (count_reg < CNT_W'(DEPTH));

    assign ctl.load  = in_fire && room;
    assign ctl.shift = out_fire;

    // Count stored values on load, flag dropped samples, count down on drain, reset at the end of a run
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_fire) begin
                    if (room) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_final) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_fire) begin
                    if (count_reg == CNT_W'(1)) begin
                        state_next   = ST_LOAD;
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    assign count           = count_reg;
    assign stat.end_of_run = (count_reg == CNT_W'(1));
    assign stat.overflow   = dropped_reg;

endmodule
